/* sv/pip_pkg.sv */
// ----------------------------------------------------------------------------
// pip_pkg: shared types and constants of the point-in-polygon test
// Holds the payload words, the controller to datapath command and status
// words, the controller state type and the register and command codes.
// ----------------------------------------------------------------------------
package pip_pkg;

    // One input word: a vertex write or a point query.
    typedef struct packed {
        logic               command;
        logic        [5:0]  vertex_index;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
    } t_in;

    // One result word.
    typedef struct packed {
        logic inside_res;
        logic on_boundary;
    } t_out;

    // Command codes of the input word.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_VERTEX_COUNT    = 2'd0;
    localparam logic [1:0] CFG_BOUNDARY_INSIDE = 2'd1;
    localparam logic [1:0] CFG_TOLERANCE       = 2'd2;

    localparam int CFG_DATA_WIDTH = 31;
    localparam int TOL_WIDTH      = 31;
    localparam int VCOUNT_WIDTH   = 7;

    // Cycles from the last vertex read until the parity and hit flags settle.
    localparam int DRAIN_CYCLES = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRIME,
        ST_EDGE,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic load_query;
        logic wr_vertex;
        logic rd_en;
        logic rd_prime;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
    } t_dp_status;

endpackage

/* sv/pip_ctrl.sv */
// ----------------------------------------------------------------------------
// pip_ctrl: sequencer of the point-in-polygon test
// Accepts words, steps the vertex reads of a query around the ring, stops
// early on a boundary hit and waits for the datapath before the result.
// ----------------------------------------------------------------------------
module pip_ctrl #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    input  logic                                    i_query,
    input  logic [pip_pkg::VCOUNT_WIDTH-1:0]        i_vertex_count,
    input  pip_pkg::t_dp_status                     i_status,
    output pip_pkg::t_dp_cmd                        o_cmd,
    output logic [$clog2(MAX_VERTICES)-1:0]         o_rd_addr,
    output logic                                    busy
);

    localparam int IW   = $clog2(MAX_VERTICES);
    localparam int CNTW = $clog2(MAX_VERTICES + 1);
    localparam int DRW  = $clog2(pip_pkg::DRAIN_CYCLES + 1);

    pip_pkg::t_state r_state, n_state;
    logic [CNTW-1:0] r_n, n_n;
    logic [IW-1:0]   r_idx, n_idx;
    logic [DRW-1:0]  r_drain, n_drain;
    logic [CNTW-1:0] sat_count;

    // Counts above the memory depth are clipped to it.
    assign sat_count = (32'(i_vertex_count) > MAX_VERTICES)
                       ? CNTW'(MAX_VERTICES) : CNTW'(i_vertex_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pip_pkg::ST_IDLE;
            r_n     <= '0;
            r_idx   <= '0;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_idx   <= n_idx;
            r_drain <= n_drain;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_n       = r_n;
        n_idx     = r_idx;
        n_drain   = r_drain;
        o_cmd     = '0;
        o_rd_addr = '0;
        case (r_state)
            pip_pkg::ST_IDLE: begin
                if (start) begin
                    if (i_query == pip_pkg::CMD_QUERY) begin
                        o_cmd.load_query = 1'b1;
                        n_n     = sat_count;
                        n_drain = DRW'(pip_pkg::DRAIN_CYCLES);
                        n_state = (sat_count == '0) ? pip_pkg::ST_DRAIN
                                                    : pip_pkg::ST_PRIME;
                    end else begin
                        o_cmd.wr_vertex = 1'b1;
                    end
                end
            end
            pip_pkg::ST_PRIME: begin
                // The last vertex closes the ring, so it is fetched first.
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_prime = 1'b1;
                o_rd_addr      = IW'(r_n - 1'b1);
                n_idx          = '0;
                n_state        = pip_pkg::ST_EDGE;
            end
            pip_pkg::ST_EDGE: begin
                if (i_status.hit) begin
                    n_state = pip_pkg::ST_DRAIN;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    o_rd_addr   = r_idx;
                    n_idx       = r_idx + 1'b1;
                    if (CNTW'(r_idx) == r_n - 1'b1) begin
                        n_state = pip_pkg::ST_DRAIN;
                    end
                end
            end
            pip_pkg::ST_DRAIN: begin
                if (r_drain == '0) begin
                    o_cmd.finish = 1'b1;
                    n_state      = pip_pkg::ST_IDLE;
                end else begin
                    n_drain = r_drain - 1'b1;
                end
            end
            default: begin
                n_state = pip_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state != pip_pkg::ST_IDLE);

    a_finish_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_state == pip_pkg::ST_IDLE)
        else $error("controller did not return to idle after a result");

    a_query_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_query == pip_pkg::CMD_QUERY) |=> busy)
        else $error("accepted query did not make the block busy");

    a_addr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_en |-> 32'(o_rd_addr) < MAX_VERTICES)
        else $error("vertex read beyond the memory depth");

    a_prime_then_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.rd_en && o_cmd.rd_prime) |=> (o_cmd.rd_en && !o_cmd.rd_prime))
        else $error("closing vertex fetch not followed by the first edge read");

endmodule

/* sv/pip_dp.sv */
// ----------------------------------------------------------------------------
// pip_dp: vertex memory and edge pipeline of the point-in-polygon test
// Stores the ring, tests one edge per cycle in a four-stage pipeline with
// exact cross products, and keeps the crossing parity and the hit flag.
// ----------------------------------------------------------------------------
module pip_dp #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_WIDTH  = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pip_pkg::t_dp_cmd                    i_cmd,
    input  logic [$clog2(MAX_VERTICES)-1:0]     i_rd_addr,
    input  pip_pkg::t_in                        i_in,
    input  logic                                i_boundary_inside,
    input  logic [pip_pkg::TOL_WIDTH-1:0]       i_tolerance,
    output pip_pkg::t_dp_status                 o_status,
    output logic                                o_result_valid,
    output pip_pkg::t_out                       o_result
);

    localparam int W   = COORD_WIDTH;
    localparam int IW  = $clog2(MAX_VERTICES);
    localparam int DW  = W + 1;
    localparam int TW  = (DW > pip_pkg::TOL_WIDTH) ? DW : pip_pkg::TOL_WIDTH;
    localparam int PW  = 2 * DW;
    localparam int P3W = pip_pkg::TOL_WIDTH + DW;
    localparam int CW  = PW + 1;
    localparam int LW  = (CW > P3W + 1) ? CW : P3W + 1;

    logic signed [W-1:0] r_mem_x [MAX_VERTICES];
    logic signed [W-1:0] r_mem_y [MAX_VERTICES];

    logic signed [W-1:0] r_rd_x, r_rd_y;
    logic                r_t0_valid, r_t0_prime;
    logic signed [W-1:0] r_vj_x, r_vj_y;
    logic signed [W-1:0] r_px, r_py;

    // Stage A: differences and range tests.
    logic                 r_va;
    logic signed [DW-1:0] r_ex, r_ey, r_dx, r_dy;
    logic        [DW-1:0] r_aex, r_aey, r_adx, r_ady;
    logic                 r_bbox_a, r_ycond_a, r_dypos_a, r_dyneg_a;
    logic signed [DW-1:0] n_ex, n_ey, n_dx, n_dy;
    logic        [DW-1:0] n_aex, n_aey, n_adx, n_ady;
    logic                 n_bbox, n_ycond;

    // Stage B: tolerance tests and products.
    logic                  r_vb;
    logic                  r_simple_b, r_sloped_b, r_ycond_b, r_dypos_b, r_dyneg_b;
    logic signed [PW-1:0]  r_p1, r_p2;
    logic        [P3W-1:0] r_p3;
    logic                  n_simple, n_sloped;

    // Stage C: cross product difference.
    logic                  r_vc;
    logic                  r_simple_c, r_sloped_c, r_ycond_c, r_dypos_c, r_dyneg_c;
    logic signed [CW-1:0]  r_c;
    logic        [P3W-1:0] r_p3_c;
    logic signed [LW-1:0]  r_np3;

    // Stage D: decision.
    logic                  r_hit, r_parity;
    logic                  d_hit, d_cross;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_vertex && (32'(i_in.vertex_index) < MAX_VERTICES)) begin
            r_mem_x[IW'(i_in.vertex_index)] <= W'(i_in.coord_x);
            r_mem_y[IW'(i_in.vertex_index)] <= W'(i_in.coord_y);
        end
        if (i_cmd.rd_en) begin
            r_rd_x <= r_mem_x[i_rd_addr];
            r_rd_y <= r_mem_y[i_rd_addr];
        end
    end

    always_comb begin
        logic px_ge, px_le_xi, xj_le_px, px_le_xj, xi_le_px;
        logic yi_le_py, py_le_yj, yj_le_py, py_le_yi;
        n_ex  = DW'(r_px)   - DW'(r_rd_x);
        n_ey  = DW'(r_py)   - DW'(r_rd_y);
        n_dx  = DW'(r_vj_x) - DW'(r_rd_x);
        n_dy  = DW'(r_vj_y) - DW'(r_rd_y);
        // Magnitudes come from opposite subtractions chosen by a compare.
        px_ge = (r_px >= r_rd_x);
        n_aex = px_ge ? DW'(r_px) - DW'(r_rd_x) : DW'(r_rd_x) - DW'(r_px);
        n_aey = (r_py >= r_rd_y) ? DW'(r_py) - DW'(r_rd_y) : DW'(r_rd_y) - DW'(r_py);
        n_adx = (r_vj_x >= r_rd_x) ? DW'(r_vj_x) - DW'(r_rd_x)
                                   : DW'(r_rd_x) - DW'(r_vj_x);
        n_ady = (r_vj_y >= r_rd_y) ? DW'(r_vj_y) - DW'(r_rd_y)
                                   : DW'(r_rd_y) - DW'(r_vj_y);
        xi_le_px = px_ge;
        px_le_xi = (r_px <= r_rd_x);
        xj_le_px = (r_vj_x <= r_px);
        px_le_xj = (r_px <= r_vj_x);
        yi_le_py = (r_rd_y <= r_py);
        py_le_yi = (r_py <= r_rd_y);
        yj_le_py = (r_vj_y <= r_py);
        py_le_yj = (r_py <= r_vj_y);
        n_bbox  = ((xi_le_px && px_le_xj) || (xj_le_px && px_le_xi)) &&
                  ((yi_le_py && py_le_yj) || (yj_le_py && py_le_yi));
        n_ycond = (yi_le_py && (r_py < r_vj_y)) || (yj_le_py && (r_py < r_rd_y));
    end

    always_comb begin
        logic vhit, horiz, vert, exok, eyok;
        exok  = (TW'(r_aex) <= TW'(i_tolerance));
        eyok  = (TW'(r_aey) <= TW'(i_tolerance));
        horiz = (TW'(r_ady) <= TW'(i_tolerance));
        vert  = (TW'(r_adx) <= TW'(i_tolerance));
        vhit  = exok && eyok;
        n_simple = vhit || (r_bbox_a && (horiz ? eyok : (vert && exok)));
        n_sloped = r_bbox_a && !horiz && !vert;
    end

    always_comb begin
        logic signed [LW-1:0] c_ext, p3_s;
        logic                 c_ok, c_neg, c_pos;
        c_ext   = LW'(r_c);
        p3_s    = $signed(LW'(r_p3_c));
        c_ok    = (c_ext <= p3_s) && (c_ext >= r_np3);
        c_neg   = r_c[CW-1];
        c_pos   = !c_neg && (r_c != '0);
        d_hit   = r_simple_c || (r_sloped_c && c_ok);
        // The ray crosses when the cross product and dy disagree in sign.
        d_cross = r_ycond_c && ((r_dypos_c && c_neg) || (r_dyneg_c && c_pos));
    end

    // Payload registers of the pipeline.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_px <= W'(i_in.coord_x);
            r_py <= W'(i_in.coord_y);
        end
        if (r_t0_valid) begin
            r_vj_x <= r_rd_x;
            r_vj_y <= r_rd_y;
        end
        r_ex      <= n_ex;
        r_ey      <= n_ey;
        r_dx      <= n_dx;
        r_dy      <= n_dy;
        r_aex     <= n_aex;
        r_aey     <= n_aey;
        r_adx     <= n_adx;
        r_ady     <= n_ady;
        r_bbox_a  <= n_bbox;
        r_ycond_a <= n_ycond;
        r_dypos_a <= (r_vj_y > r_rd_y);
        r_dyneg_a <= (r_vj_y < r_rd_y);

        r_simple_b <= n_simple;
        r_sloped_b <= n_sloped;
        r_ycond_b  <= r_ycond_a;
        r_dypos_b  <= r_dypos_a;
        r_dyneg_b  <= r_dyneg_a;
        r_p1       <= PW'(r_dx) * PW'(r_ey);
        r_p2       <= PW'(r_dy) * PW'(r_ex);
        r_p3       <= P3W'(i_tolerance) * P3W'(r_adx);

        r_simple_c <= r_simple_b;
        r_sloped_c <= r_sloped_b;
        r_ycond_c  <= r_ycond_b;
        r_dypos_c  <= r_dypos_b;
        r_dyneg_c  <= r_dyneg_b;
        r_c        <= CW'(r_p1) - CW'(r_p2);
        r_p3_c     <= r_p3;
        r_np3      <= -$signed(LW'(r_p3));
    end

    // Control registers of the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t0_valid     <= 1'b0;
            r_t0_prime     <= 1'b0;
            r_va           <= 1'b0;
            r_vb           <= 1'b0;
            r_vc           <= 1'b0;
            r_hit          <= 1'b0;
            r_parity       <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            r_t0_valid <= i_cmd.rd_en;
            r_t0_prime <= i_cmd.rd_prime;
            r_va       <= r_t0_valid && !r_t0_prime;
            r_vb       <= r_va;
            r_vc       <= r_vb;
            if (i_cmd.load_query) begin
                r_hit    <= 1'b0;
                r_parity <= 1'b0;
            end else if (r_vc && !r_hit) begin
                // Edges still in flight after a hit are ignored.
                if (d_hit) begin
                    r_hit <= 1'b1;
                end else if (d_cross) begin
                    r_parity <= !r_parity;
                end
            end
            o_result_valid <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_result.inside_res  <= r_hit ? i_boundary_inside : r_parity;
            o_result.on_boundary <= r_hit;
        end
    end

    assign o_status.hit = r_hit;

endmodule

/* sv/point_in_polygon_test.sv */
// ----------------------------------------------------------------------------
// point_in_polygon_test: point-in-polygon test with boundary detection
// Vertex writes fill the ring memory; a query walks the edges one per cycle,
// stops at a boundary hit and gives the point's inside and on-boundary flags.
// ----------------------------------------------------------------------------
// A vertex write gives no result word.
// A query shows its result word in the same cycle in which busy falls, so the
// next word can be taken then; a boundary hit ends the walk early.
// The rate is set by the single read port of the vertex memory: one edge a
// cycle, followed by the four-stage edge pipeline draining.
// Reset sets vertex_count 3, boundary_inside 1, tolerance 0; memory is kept.
module point_in_polygon_test #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_WIDTH  = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  pip_pkg::t_in                         i_in,
    output logic                                 o_result_valid,
    output pip_pkg::t_out                        o_result,
    input  logic                                 i_cfg_we,
    input  logic [1:0]                           i_cfg_idx,
    input  logic [pip_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data
);

    logic [pip_pkg::VCOUNT_WIDTH-1:0] r_vertex_count;
    logic                             r_boundary_inside;
    logic [pip_pkg::TOL_WIDTH-1:0]    r_tolerance;

    pip_pkg::t_dp_cmd                 cmd;
    pip_pkg::t_dp_status              status;
    logic [$clog2(MAX_VERTICES)-1:0]  rd_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count    <= pip_pkg::VCOUNT_WIDTH'(3);
            r_boundary_inside <= 1'b1;
            r_tolerance       <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pip_pkg::CFG_VERTEX_COUNT: begin
                    r_vertex_count <= i_cfg_data[pip_pkg::VCOUNT_WIDTH-1:0];
                end
                pip_pkg::CFG_BOUNDARY_INSIDE: begin
                    r_boundary_inside <= i_cfg_data[0];
                end
                pip_pkg::CFG_TOLERANCE: begin
                    r_tolerance <= i_cfg_data[pip_pkg::TOL_WIDTH-1:0];
                end
                default: begin
                    r_tolerance <= r_tolerance;
                end
            endcase
        end
    end

    pip_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_query        (i_in.command),
        .i_vertex_count (r_vertex_count),
        .i_status       (status),
        .o_cmd          (cmd),
        .o_rd_addr      (rd_addr),
        .busy           (busy)
    );

    pip_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_rd_addr         (rd_addr),
        .i_in              (i_in),
        .i_boundary_inside (r_boundary_inside),
        .i_tolerance       (r_tolerance),
        .o_status          (status),
        .o_result_valid    (o_result_valid),
        .o_result          (o_result)
    );

endmodule

/* tb/pip_checker.sv */
// ----------------------------------------------------------------------------
// pip_checker: result predictor and scoreboard of the point-in-polygon test
// Watches the command, result and register channels of the block. It keeps
// its own copy of the vertex ring and the registers and predicts the inside
// and on-boundary flags of every accepted query that its queue can hold.
// Each result word is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module pip_checker #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic                                 i_busy,
    input  pip_pkg::t_in                         i_word,
    input  logic                                 i_result_valid,
    input  pip_pkg::t_out                        i_result,
    input  logic                                 i_cfg_we,
    input  logic [1:0]                           i_cfg_idx,
    input  logic [pip_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data,
    output int                                   o_fail_count,
    output int                                   o_pending,
    output int                                   o_checked,
    output int                                   o_boundary_hits
);

    // Wide enough for every cross product of 33-bit differences.
    typedef logic signed [127:0] t_wide;

    localparam int VERDICT_DEPTH = 16;

    longint                             vert_x [MAX_VERTICES];
    longint                             vert_y [MAX_VERTICES];
    logic [pip_pkg::VCOUNT_WIDTH-1:0]   vert_count;
    logic                               bnd_inside;
    longint                             tol;

    // Predictions waiting for their result word, oldest at verdict_head.
    pip_pkg::t_out                      awaited_verdicts [VERDICT_DEPTH];
    int                                 verdict_head;
    int                                 verdict_tail;
    int                                 verdict_count;
    int                                 fails;
    int                                 checked;
    int                                 hits;

    initial begin
        fails         = 0;
        checked       = 0;
        hits          = 0;
        verdict_head  = 0;
        verdict_tail  = 0;
        verdict_count = 0;
    end

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // True when the point touches edge (j,i); otherwise flips odd on a crossing
    // of the leftward ray.
    function automatic bit edge_hits_point(input longint px, input longint py,
                                           input int i, input int j, inout bit odd);
        longint xi, yi, xj, yj, ex, ey, dx, dy;
        t_wide  cprod, bound;
        xi = vert_x[i];
        yi = vert_y[i];
        xj = vert_x[j];
        yj = vert_y[j];
        ex = px - xi;
        ey = py - yi;
        dx = xj - xi;
        dy = yj - yi;

        if (mag(ex) <= tol && mag(ey) <= tol)
            return 1'b1;

        if (((xi < xj) ? xi : xj) <= px && px <= ((xi > xj) ? xi : xj) &&
            ((yi < yj) ? yi : yj) <= py && py <= ((yi > yj) ? yi : yj)) begin
            if (mag(dy) <= tol) begin
                if (mag(ey) <= tol)
                    return 1'b1;
            end else if (mag(dx) <= tol) begin
                if (mag(ex) <= tol)
                    return 1'b1;
            end else begin
                // Vertical distance to the sloped line, scaled by |dx| to stay exact.
                cprod = t_wide'(dx) * t_wide'(ey) - t_wide'(dy) * t_wide'(ex);
                if (cprod < 0)
                    cprod = -cprod;
                bound = t_wide'(tol) * t_wide'(mag(dx));
                if (cprod <= bound)
                    return 1'b1;
            end
        end

        // Half-open in y, so a ray through a shared vertex counts once.
        if ((yi <= py && py < yj) || (yj <= py && py < yi)) begin
            cprod = t_wide'(ex) * t_wide'(dy) - t_wide'(ey) * t_wide'(dx);
            if ((dy > 0 && cprod > 0) || (dy < 0 && cprod < 0))
                odd = !odd;
        end
        return 1'b0;
    endfunction

    function automatic pip_pkg::t_out ring_verdict(input longint px, input longint py);
        pip_pkg::t_out v;
        int            n, i, j;
        bit            odd, hit;
        n   = (vert_count > MAX_VERTICES) ? MAX_VERTICES : int'(vert_count);
        odd = 1'b0;
        hit = 1'b0;
        j   = (n > 0) ? n - 1 : 0;
        for (i = 0; i < n && !hit; i++) begin
            hit = edge_hits_point(px, py, i, j, odd);
            j   = i;
        end
        v.inside_res  = hit ? bnd_inside : odd;
        v.on_boundary = hit;
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fails++;
    endtask

    always @(posedge i_clk) begin
        pip_pkg::t_out want;
        if (!i_rst_n) begin
            vert_count    = pip_pkg::VCOUNT_WIDTH'(3);
            bnd_inside    = 1'b1;
            tol           = 0;
            verdict_head  = 0;
            verdict_tail  = 0;
            verdict_count = 0;
        end else begin
            if (i_result_valid) begin
                if (verdict_count == 0) begin
                    report_mismatch($sformatf("result word %b with no query outstanding",
                                              i_result));
                end else begin
                    want          = awaited_verdicts[verdict_head];
                    verdict_head  = (verdict_head + 1) % VERDICT_DEPTH;
                    verdict_count--;
                    if (i_result.inside_res !== want.inside_res)
                        report_mismatch($sformatf("result %0d: inside_res %b, expected %b",
                                                  checked, i_result.inside_res,
                                                  want.inside_res));
                    if (i_result.on_boundary !== want.on_boundary)
                        report_mismatch($sformatf("result %0d: on_boundary %b, expected %b",
                                                  checked, i_result.on_boundary,
                                                  want.on_boundary));
                    if (want.on_boundary)
                        hits++;
                    checked++;
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pip_pkg::CFG_VERTEX_COUNT:
                        vert_count = i_cfg_data[pip_pkg::VCOUNT_WIDTH-1:0];
                    pip_pkg::CFG_BOUNDARY_INSIDE:
                        bnd_inside = i_cfg_data[0];
                    pip_pkg::CFG_TOLERANCE:
                        tol = longint'(i_cfg_data[pip_pkg::TOL_WIDTH-1:0]);
                    default: ;
                endcase
            end

            if (i_start && !i_busy) begin
                if (i_word.command == pip_pkg::CMD_WRITE) begin
                    if (i_word.vertex_index < MAX_VERTICES) begin
                        vert_x[i_word.vertex_index] = longint'($signed(i_word.coord_x));
                        vert_y[i_word.vertex_index] = longint'($signed(i_word.coord_y));
                    end
                end else if (verdict_count == VERDICT_DEPTH) begin
                    report_mismatch("more queries outstanding than the checker can hold");
                end else begin
                    awaited_verdicts[verdict_tail] =
                        ring_verdict(longint'($signed(i_word.coord_x)),
                                     longint'($signed(i_word.coord_y)));
                    verdict_tail = (verdict_tail + 1) % VERDICT_DEPTH;
                    verdict_count++;
                end
            end
        end
        o_fail_count    <= fails;
        o_pending       <= verdict_count;
        o_checked       <= checked;
        o_boundary_hits <= hits;
    end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench of the point-in-polygon test
// Writes polygons of many shapes and sizes under several register settings
// and fires query points at their vertices, edges, interiors and far away.
// A checker beside the block predicts and compares every result word; this
// module makes the stimulus, pauses the sender at random and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int     TOTAL_WORDS  = 1875;
    localparam int     CYCLE_LIMIT  = 800000;
    localparam longint ONE          = 65536;
    localparam longint COORD_MAX    = 64'sd2147483647;
    localparam longint COORD_MIN    = -64'sd2147483648;
    localparam logic [pip_pkg::TOL_WIDTH-1:0] TOL_MAX = '1;

    localparam int STYLE_SCATTER = 0;
    localparam int STYLE_GRID    = 1;
    localparam int STYLE_WIDE    = 2;

    logic                                clk;
    logic                                rst_n;
    logic                                start;
    logic                                busy;
    pip_pkg::t_in                        in_word;
    logic                                result_valid;
    pip_pkg::t_out                       result;
    logic                                cfg_we;
    logic [1:0]                          cfg_idx;
    logic [pip_pkg::CFG_DATA_WIDTH-1:0]  cfg_data;

    int fail_count, pending, checked, boundary_hits;
    int words_sent, queries_sent, writes_sent, settings_used;
    int cycle_count;

    // Local copy of the ring, used only to aim query points.
    longint poly_x [64];
    longint poly_y [64];
    int     ring;
    longint box_x_lo, box_x_hi, box_y_lo, box_y_hi;

    point_in_polygon_test #(
        .MAX_VERTICES (64),
        .COORD_WIDTH  (32)
    ) i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .start          (start),
        .busy           (busy),
        .i_in           (in_word),
        .o_result_valid (result_valid),
        .o_result       (result),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data)
    );

    pip_checker #(
        .MAX_VERTICES (64)
    ) i_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_word          (in_word),
        .i_result_valid  (result_valid),
        .i_result        (result),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_boundary_hits (boundary_hits)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding",
                 cycle_count, pending);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic longint rand_between(input longint lo, input longint hi);
        longint unsigned span, r;
        if (hi <= lo)
            return lo;
        span = longint'(hi - lo) + 1;
        r    = {$urandom, $urandom};
        return lo + longint'(r % span);
    endfunction

    function automatic longint full_coord();
        return longint'($signed($urandom));
    endfunction

    task automatic refresh_box();
        box_x_lo = 0;
        box_x_hi = 0;
        box_y_lo = 0;
        box_y_hi = 0;
        for (int k = 0; k < ring; k++) begin
            if (k == 0 || poly_x[k] < box_x_lo) box_x_lo = poly_x[k];
            if (k == 0 || poly_x[k] > box_x_hi) box_x_hi = poly_x[k];
            if (k == 0 || poly_y[k] < box_y_lo) box_y_lo = poly_y[k];
            if (k == 0 || poly_y[k] > box_y_hi) box_y_hi = poly_y[k];
        end
    endtask

    // The sender idles often early on, more so in the middle, and not at all
    // in the last third of the run.
    task automatic send_word(input pip_pkg::t_in w);
        int  idle_pct;
        bit  taken;
        idle_pct = (words_sent * 3 < TOTAL_WORDS) ? 31 :
                   (words_sent * 3 < 2 * TOTAL_WORDS) ? 51 : 0;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start   <= 1'b1;
        in_word <= w;
        taken = 1'b0;
        while (!taken) begin
            @(posedge clk);
            taken = !busy;
            @(negedge clk);
        end
        words_sent++;
    endtask

    task automatic put_vertex(input int slot, input longint x, input longint y);
        pip_pkg::t_in w;
        w.command      = pip_pkg::CMD_WRITE;
        w.vertex_index = slot[5:0];
        w.coord_x      = x[31:0];
        w.coord_y      = y[31:0];
        poly_x[slot]   = longint'($signed(w.coord_x));
        poly_y[slot]   = longint'($signed(w.coord_y));
        refresh_box();
        send_word(w);
        writes_sent++;
    endtask

    task automatic ask_point(input longint x, input longint y);
        pip_pkg::t_in w;
        w.command      = pip_pkg::CMD_QUERY;
        w.vertex_index = 6'($urandom);
        w.coord_x      = x[31:0];
        w.coord_y      = y[31:0];
        send_word(w);
        queries_sent++;
    endtask

    // Holds the sender until every result is in and the block is idle again.
    task automatic drain_block();
        bit idle_seen;
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        idle_seen = 1'b0;
        while (!idle_seen) begin
            @(posedge clk);
            idle_seen = !busy;
            @(negedge clk);
        end
        repeat (pip_pkg::DRAIN_CYCLES + 4) @(negedge clk);
    endtask

    task automatic reconfigure(input int count, input bit bnd_in,
                               input logic [pip_pkg::TOL_WIDTH-1:0] tol);
        drain_block();
        cfg_we   <= 1'b1;
        cfg_idx  <= pip_pkg::CFG_VERTEX_COUNT;
        cfg_data <= pip_pkg::CFG_DATA_WIDTH'(count);
        @(negedge clk);
        cfg_idx  <= pip_pkg::CFG_BOUNDARY_INSIDE;
        cfg_data <= pip_pkg::CFG_DATA_WIDTH'(bnd_in);
        @(negedge clk);
        cfg_idx  <= pip_pkg::CFG_TOLERANCE;
        cfg_data <= pip_pkg::CFG_DATA_WIDTH'(tol);
        @(negedge clk);
        cfg_we   <= 1'b0;
        ring = (count > 64) ? 64 : count;
        refresh_box();
        settings_used++;
    endtask

    task automatic build_polygon(input int style);
        longint x, y, s;
        s = longint'(1) << $urandom_range(2, 28);
        x = 0;
        y = 0;
        for (int k = 0; k < ring; k++) begin
            case (style)
                STYLE_SCATTER: begin
                    x = rand_between(-s, s);
                    y = rand_between(-s, s);
                end
                STYLE_GRID: begin
                    // Alternate x and y steps give horizontal and vertical edges.
                    if (k % 2 == 0)
                        x = rand_between(-8, 8) * ONE;
                    else
                        y = rand_between(-8, 8) * ONE;
                end
                default: begin
                    x = full_coord();
                    y = full_coord();
                end
            endcase
            put_vertex(k, x, y);
        end
    endtask

    // Aims at vertices, near misses, edge midpoints, vertex rows and the
    // bounding box, with a few points anywhere.
    task automatic pick_query(output longint x, output longint y);
        int a, b, r;
        r = $urandom_range(99);
        if (ring == 0 || r >= 90) begin
            x = full_coord();
            y = full_coord();
        end else begin
            a = $urandom_range(ring - 1);
            b = (a + 1) % ring;
            if (r < 18) begin
                x = poly_x[a];
                y = poly_y[a];
            end else if (r < 32) begin
                x = poly_x[a] + rand_between(-4, 4);
                y = poly_y[a] + rand_between(-4, 4);
            end else if (r < 50) begin
                x = (poly_x[a] + poly_x[b]) >>> 1;
                y = (poly_y[a] + poly_y[b]) >>> 1;
            end else if (r < 60) begin
                x = rand_between(box_x_lo - 2, box_x_hi + 2);
                y = poly_y[a];
            end else begin
                x = rand_between(box_x_lo - 2, box_x_hi + 2);
                y = rand_between(box_y_lo - 2, box_y_hi + 2);
            end
        end
    endtask

    task automatic run_directed();
        // Registers still hold their reset values: three vertices, tolerance 0.
        put_vertex(0, 0, 0);
        put_vertex(1, 10 * ONE, 0);
        put_vertex(2, 0, 10 * ONE);
        ask_point(0, 0);
        ask_point(5 * ONE, 0);
        ask_point(0, 5 * ONE);
        ask_point(5 * ONE, 5 * ONE);
        ask_point(ONE, ONE);
        ask_point(20 * ONE, ONE);
        ask_point(-ONE, 0);
        ask_point(COORD_MAX, COORD_MAX);
        ask_point(COORD_MIN, COORD_MIN);
        put_vertex(63, COORD_MAX, COORD_MIN);

        reconfigure(0, 1'b0, '0);
        ask_point(ONE, ONE);

        // A single vertex closes on itself.
        reconfigure(1, 1'b0, 2);
        ask_point(1, 2);
        ask_point(5 * ONE, 5 * ONE);

        reconfigure(2, 1'b1, TOL_MAX);
        ask_point(3 * ONE, 7 * ONE);
        ask_point(COORD_MIN, COORD_MIN);

        put_vertex(0, COORD_MIN, COORD_MIN);
        put_vertex(1, COORD_MAX, COORD_MIN);
        put_vertex(2, COORD_MIN, COORD_MAX);
        reconfigure(3, 1'b1, '0);
        ask_point(0, 0);
        ask_point(COORD_MAX, COORD_MAX);
        ask_point(COORD_MIN, COORD_MIN);
    endtask

    initial begin
        int                            n, r, m, phase;
        bit                            bnd_in;
        logic [pip_pkg::TOL_WIDTH-1:0] tol;
        longint                        x, y;

        start         = 1'b0;
        in_word       = '0;
        cfg_we        = 1'b0;
        cfg_idx       = pip_pkg::CFG_VERTEX_COUNT;
        cfg_data      = '0;
        rst_n         = 1'b0;
        words_sent    = 0;
        queries_sent  = 0;
        writes_sent   = 0;
        settings_used = 0;
        ring          = 3;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();

        phase = 0;
        while (words_sent < TOTAL_WORDS) begin
            r = $urandom_range(99);
            if (phase == 0)
                n = 127;
            else if (r < 6)
                n = $urandom_range(0, 2);
            else if (r < 14)
                n = (r % 2 == 0) ? 64 : $urandom_range(65, 127);
            else
                n = $urandom_range(3, 12);

            r = $urandom_range(99);
            if (r < 45)
                tol = '0;
            else if (r < 70)
                tol = pip_pkg::TOL_WIDTH'($urandom_range(1, 4));
            else if (r < 82)
                tol = pip_pkg::TOL_WIDTH'($urandom_range(5, 1 << 17));
            else if (r < 92)
                tol = pip_pkg::TOL_WIDTH'($urandom);
            else
                tol = TOL_MAX;

            bnd_in = 1'($urandom);
            reconfigure(n, bnd_in, tol);

            r = $urandom_range(99);
            build_polygon((r < 45) ? STYLE_SCATTER : (r < 80) ? STYLE_GRID : STYLE_WIDE);

            m = (ring > 32) ? $urandom_range(20, 40) : $urandom_range(30, 70);
            repeat (m) begin
                r = $urandom_range(99);
                if (r < 8) begin
                    if (r < 4) begin
                        x = full_coord();
                        y = full_coord();
                    end else begin
                        x = rand_between(box_x_lo, box_x_hi);
                        y = rand_between(box_y_lo, box_y_hi);
                    end
                    put_vertex($urandom_range(63), x, y);
                end else begin
                    pick_query(x, y);
                    ask_point(x, y);
                end
                if (r == 99)
                    drain_block();
            end
            phase++;
        end

        drain_block();
        repeat (80) @(negedge clk);

        $display("Sent %0d vertex writes and %0d point queries under %0d register settings.",
                 writes_sent, queries_sent, settings_used);
        $display("Checked %0d result words, %0d of them boundary hits.",
                 checked, boundary_hits);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
